// File: src/mpfb_pkg.sv
// shared types and constants for the max pooling unit
package mpfb_pkg;
    localparam int DATA_BITS    = 16;
    localparam int CHAN_BITS    = 4;
    localparam int DIM_BITS     = 6;
    localparam int WIN_BITS     = 3;
    localparam int MAX_CHANNELS = 16;
    localparam int MAX_DIM      = 64;
    localparam int MAX_WINDOW   = 8;
    localparam int ADDR_BITS    = CHAN_BITS + 2 * DIM_BITS;
    localparam int PADDR_BITS   = 5;

    localparam logic [PADDR_BITS-1:0] ADDR_NUM_CHANNELS  = 5'd0;
    localparam logic [PADDR_BITS-1:0] ADDR_IMAGE_HEIGHT  = 5'd4;
    localparam logic [PADDR_BITS-1:0] ADDR_IMAGE_WIDTH   = 5'd8;
    localparam logic [PADDR_BITS-1:0] ADDR_WINDOW_HEIGHT = 5'd12;
    localparam logic [PADDR_BITS-1:0] ADDR_WINDOW_WIDTH  = 5'd16;

    localparam logic OP_FWD = 1'b0;
    localparam logic OP_BWD = 1'b1;
    localparam logic KIND_MAX = 1'b0;
    localparam logic KIND_ERR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_BWD_RD,
        ST_BWD_EMIT,
        ST_BWD_WAIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic fwd_go;
        logic bwd_start;
        logic bwd_read;
        logic bwd_step;
        logic bwd_done;
        logic restart;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic fwd_emit;
        logic bwd_none;
        logic bwd_last;
    } t_status;
endpackage

// File: src/mpfb_stream_if.sv
// valid/ready stream interfaces for items and results
interface mpfb_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  op;
    logic signed [mpfb_pkg::DATA_BITS-1:0] sample;
    modport source (output valid, op, sample, input ready);
    modport sink   (input valid, op, sample, output ready);
endinterface

interface mpfb_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic signed [mpfb_pkg::DATA_BITS-1:0] result_value;
    logic [mpfb_pkg::CHAN_BITS-1:0]        chan_index;
    logic [mpfb_pkg::DIM_BITS-1:0]         row_index;
    logic [mpfb_pkg::DIM_BITS-1:0]         col_index;
    logic                                  last;
    modport source (output valid, kind, result_value, chan_index, row_index, col_index, last,
                    input ready);
    modport sink   (input valid, kind, result_value, chan_index, row_index, col_index, last,
                    output ready);
endinterface

// File: src/max_pooling_fwd_bwd_unit.sv
// top level of the 2-D max pooling unit, forward and backward
// usage:
//   in channel: op 0 carries a pixel in channel, row, column raster order,
//   op 1 an output gradient in pooled raster order
//   out channel: kind 0 a pooled maximum, kind 1 an input error; last marks
//   the final result of an item
//   apb port: num_channels, image_height, image_width, window_height,
//   window_width at 0, 4, 8, 12, 16; a write to any of these restarts both positions
// timing:
//   pixels are taken one per cycle while idle with the output register free
//   or being taken; the window maximum appears in the output register the
//   cycle after its last pixel; each gradient error needs one read of the
//   single-port pixel store and one output load
// reset clears the positions and the output valid; stores are undefined until
// written by a forward pass
// when the receiver stalls the result holds in the output register and no
// new item is taken
module max_pooling_fwd_bwd_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mpfb_in_if.sink                      in_ch,
    mpfb_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mpfb_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    logic [4:0] r_nc;
    logic [6:0] r_ih, r_iw;
    logic [3:0] r_wh, r_ww;
    logic [4:0] nc;
    logic [6:0] ih, iw;
    logic [3:0] wh, ww;
    logic       cfg_wr, restart, load, in_ready, r_valid, take;
    mpfb_pkg::t_cmd    cmd;
    mpfb_pkg::t_status status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign restart = cfg_wr && (paddr == mpfb_pkg::ADDR_NUM_CHANNELS ||
                                paddr == mpfb_pkg::ADDR_IMAGE_HEIGHT ||
                                paddr == mpfb_pkg::ADDR_IMAGE_WIDTH ||
                                paddr == mpfb_pkg::ADDR_WINDOW_HEIGHT ||
                                paddr == mpfb_pkg::ADDR_WINDOW_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc <= 5'd1; r_ih <= 7'd64; r_iw <= 7'd64; r_wh <= 4'd2; r_ww <= 4'd2;
        end else if (cfg_wr) begin
            case (paddr)
                mpfb_pkg::ADDR_NUM_CHANNELS:  r_nc <= pwdata[4:0];
                mpfb_pkg::ADDR_IMAGE_HEIGHT:  r_ih <= pwdata[6:0];
                mpfb_pkg::ADDR_IMAGE_WIDTH:   r_iw <= pwdata[6:0];
                mpfb_pkg::ADDR_WINDOW_HEIGHT: r_wh <= pwdata[3:0];
                mpfb_pkg::ADDR_WINDOW_WIDTH:  r_ww <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            mpfb_pkg::ADDR_NUM_CHANNELS:  prdata = {27'd0, r_nc};
            mpfb_pkg::ADDR_IMAGE_HEIGHT:  prdata = {25'd0, r_ih};
            mpfb_pkg::ADDR_IMAGE_WIDTH:   prdata = {25'd0, r_iw};
            mpfb_pkg::ADDR_WINDOW_HEIGHT: prdata = {28'd0, r_wh};
            mpfb_pkg::ADDR_WINDOW_WIDTH:  prdata = {28'd0, r_ww};
            default:                      prdata = '0;
        endcase
    end

    // clamp sizes to legal range
    assign nc = (r_nc == '0) ? 5'd1 : (r_nc > 5'd16) ? 5'd16 : r_nc;
    assign ih = (r_ih == '0) ? 7'd1 : (r_ih > 7'd64) ? 7'd64 : r_ih;
    assign iw = (r_iw == '0) ? 7'd1 : (r_iw > 7'd64) ? 7'd64 : r_iw;
    assign wh = (r_wh == '0) ? 4'd1 : (r_wh > 4'd8) ? 4'd8 : r_wh;
    assign ww = (r_ww == '0) ? 4'd1 : (r_ww > 4'd8) ? 4'd8 : r_ww;

    assign take = r_valid && out_ch.ready;

    mpfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_in_op    (in_ch.op),
        .i_out_busy (r_valid),
        .i_out_take (take),
        .i_restart  (restart),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_load     (load),
        .o_cmd      (cmd)
    );

    mpfb_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_sample (in_ch.sample),
        .i_nc     (nc),
        .i_ih     (ih),
        .i_iw     (iw),
        .i_wh     (wh),
        .i_ww     (ww),
        .o_status (status),
        .o_kind   (out_ch.kind),
        .o_value  (out_ch.result_value),
        .o_chan   (out_ch.chan_index),
        .o_row    (out_ch.row_index),
        .o_col    (out_ch.col_index),
        .o_last   (out_ch.last)
    );

    assign in_ch.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (take) begin
            r_valid <= 1'b0;
        end
    end

    assign out_ch.valid = r_valid;

`ifndef SYNTH
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_valid || take))
        else $error("output register overwritten");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.fwd_go, cmd.bwd_start, cmd.bwd_step, cmd.bwd_done}) <= 1)
        else $error("conflicting datapath commands");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !out_ch.ready) |=> r_valid)
        else $error("result dropped");
`endif
endmodule

// File: src/mpfb_ctrl.sv
// controller state machine for forward and backward passes
module mpfb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_op,
    input  logic                 i_out_busy,
    input  logic                 i_out_take,
    input  logic                 i_restart,
    input  mpfb_pkg::t_status    i_status,
    output logic                 o_in_ready,
    output logic                 o_load,
    output mpfb_pkg::t_cmd       o_cmd
);
    mpfb_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpfb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_load     = 1'b0;
        o_cmd      = '0;
        o_cmd.restart = i_restart;
        case (r_state)
            mpfb_pkg::ST_IDLE: begin
                o_in_ready = !i_out_busy || i_out_take;
                if (i_in_valid && o_in_ready) begin
                    if (i_in_op == mpfb_pkg::OP_FWD) begin
                        o_cmd.fwd_go = 1'b1;
                        o_load       = i_status.fwd_emit;
                    end else begin
                        o_cmd.bwd_start = 1'b1;
                        n_state = mpfb_pkg::ST_BWD_RD;
                    end
                end
            end
            mpfb_pkg::ST_BWD_RD: begin
                if (i_status.bwd_none) begin
                    n_state = mpfb_pkg::ST_IDLE;
                end else begin
                    o_cmd.bwd_read = 1'b1;
                    n_state = mpfb_pkg::ST_BWD_EMIT;
                end
            end
            mpfb_pkg::ST_BWD_EMIT: begin
                if (!i_out_busy || i_out_take) begin
                    o_load = 1'b1;
                    if (i_status.bwd_last) begin
                        o_cmd.bwd_done = 1'b1;
                        n_state = mpfb_pkg::ST_IDLE;
                    end else begin
                        o_cmd.bwd_step = 1'b1;
                        n_state = mpfb_pkg::ST_BWD_WAIT;
                    end
                end
            end
            mpfb_pkg::ST_BWD_WAIT: begin
                o_cmd.bwd_read = 1'b1;
                n_state = mpfb_pkg::ST_BWD_EMIT;
            end
            default: n_state = mpfb_pkg::ST_IDLE;
        endcase
    end
endmodule

// File: src/mpfb_datapath.sv
// counters, stores and compare logic for pooling
module mpfb_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mpfb_pkg::t_cmd                        i_cmd,
    input  logic signed [mpfb_pkg::DATA_BITS-1:0] i_sample,
    input  logic [mpfb_pkg::CHAN_BITS:0]          i_nc,
    input  logic [mpfb_pkg::DIM_BITS:0]           i_ih,
    input  logic [mpfb_pkg::DIM_BITS:0]           i_iw,
    input  logic [mpfb_pkg::WIN_BITS:0]           i_wh,
    input  logic [mpfb_pkg::WIN_BITS:0]           i_ww,
    output mpfb_pkg::t_status                     o_status,
    output logic                                  o_kind,
    output logic signed [mpfb_pkg::DATA_BITS-1:0] o_value,
    output logic [mpfb_pkg::CHAN_BITS-1:0]        o_chan,
    output logic [mpfb_pkg::DIM_BITS-1:0]         o_row,
    output logic [mpfb_pkg::DIM_BITS-1:0]         o_col,
    output logic                                  o_last
);
    localparam int AB = mpfb_pkg::ADDR_BITS;
    localparam int DB = mpfb_pkg::DATA_BITS;
    localparam int CB = mpfb_pkg::CHAN_BITS;
    localparam int PB = mpfb_pkg::DIM_BITS;
    localparam int WB = mpfb_pkg::WIN_BITS;

    logic [DB-1:0] r_pixel_mem [0:(1<<AB)-1];
    logic [DB-1:0] r_max_mem   [0:(1<<AB)-1];
    logic [DB-1:0] r_partial   [0:mpfb_pkg::MAX_DIM-1];

    // forward position, split into window and offset counters
    logic [CB-1:0] r_fc;
    logic [PB-1:0] r_fr, r_fcol, r_fhh, r_fwc;
    logic [WB-1:0] r_fmh, r_fmw;
    // backward position
    logic [CB-1:0] r_bc;
    logic [PB-1:0] r_bhh, r_bwc, r_br0, r_bc0;
    logic [WB-1:0] r_bmh, r_bmw;
    logic [DB-1:0] r_mx, r_pix, r_grad;
    // running maximum of the current output column, fetched ahead
    logic [DB-1:0] r_pm;
    logic [PB-1:0] n_fwc;

    logic [PB:0] oh, ow;
    logic        f_in, f_end, mh_last, mw_last;
    logic [DB-1:0] pm_cur, pm_new;

    // output size by repeated compare, small widths
    always_comb begin
        oh = '0;
        ow = '0;
        for (int k = 1; k <= mpfb_pkg::MAX_DIM; k++) begin
            if ((PB+WB+1)'(k) * (PB+WB+1)'(i_wh) <= (PB+WB+1)'(i_ih)) oh = (PB+1)'(k);
            if ((PB+WB+1)'(k) * (PB+WB+1)'(i_ww) <= (PB+WB+1)'(i_iw)) ow = (PB+1)'(k);
        end
    end

    assign mh_last = ({1'b0, r_fmh} == i_wh - 1'b1);
    assign mw_last = ({1'b0, r_fmw} == i_ww - 1'b1);
    assign f_in    = ({1'b0, r_fhh} < oh) && ({1'b0, r_fwc} < ow);
    assign f_end   = f_in && mh_last && mw_last;
    assign pm_cur  = r_pm;
    assign pm_new  = ((r_fmh == '0 && r_fmw == '0) || $signed(i_sample) > $signed(pm_cur))
                     ? i_sample : pm_cur;

    // output column of the next pixel
    always_comb begin
        if ({1'b0, r_fcol} == i_iw - 1'b1) begin
            n_fwc = '0;
        end else if (mw_last) begin
            n_fwc = r_fwc + 1'b1;
        end else begin
            n_fwc = r_fwc;
        end
    end

    assign o_status.fwd_emit = f_end;
    assign o_status.bwd_none = (oh == '0) || (ow == '0);
    assign o_status.bwd_last = ({1'b0, r_bmh} == i_wh - 1'b1) && ({1'b0, r_bmw} == i_ww - 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.fwd_go && f_in) begin
            r_pixel_mem[{r_fc, r_fr, r_fcol}] <= i_sample;
            r_partial[r_fwc] <= pm_new;
        end
        if (i_cmd.fwd_go) begin
            r_pm <= (f_in && n_fwc == r_fwc) ? pm_new : r_partial[n_fwc];
        end
        if (i_cmd.fwd_go && f_end) begin
            r_max_mem[{r_fc, r_fhh, r_fwc}] <= pm_new;
        end
        if (i_cmd.bwd_read) begin
            r_pix <= r_pixel_mem[{r_bc, r_br0 + PB'(r_bmh), r_bc0 + PB'(r_bmw)}];
        end
        if (i_cmd.bwd_start) begin
            r_mx   <= r_max_mem[{r_bc, r_bhh, r_bwc}];
            r_grad <= i_sample;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.fwd_go) begin
            o_kind  <= mpfb_pkg::KIND_MAX;
            o_value <= pm_new;
            o_chan  <= r_fc;
            o_row   <= r_fhh;
            o_col   <= r_fwc;
            o_last  <= 1'b1;
        end else if (i_cmd.bwd_step || i_cmd.bwd_done) begin
            o_kind  <= mpfb_pkg::KIND_ERR;
            o_value <= (r_pix == r_mx) ? r_grad : '0;
            o_chan  <= r_bc;
            o_row   <= r_br0 + PB'(r_bmh);
            o_col   <= r_bc0 + PB'(r_bmw);
            o_last  <= i_cmd.bwd_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_fc <= '0; r_fr <= '0; r_fcol <= '0; r_fhh <= '0; r_fwc <= '0;
            r_fmh <= '0; r_fmw <= '0;
            r_bc <= '0; r_bhh <= '0; r_bwc <= '0; r_br0 <= '0; r_bc0 <= '0;
            r_bmh <= '0; r_bmw <= '0;
        end else begin
            if (i_cmd.fwd_go) begin
                if ({1'b0, r_fcol} == i_iw - 1'b1) begin
                    r_fcol <= '0; r_fwc <= '0; r_fmw <= '0;
                    if ({1'b0, r_fr} == i_ih - 1'b1) begin
                        r_fr <= '0; r_fhh <= '0; r_fmh <= '0;
                        r_fc <= ({1'b0, r_fc} == i_nc - 1'b1) ? '0 : r_fc + 1'b1;
                    end else begin
                        r_fr <= r_fr + 1'b1;
                        if (mh_last) begin
                            r_fmh <= '0; r_fhh <= r_fhh + 1'b1;
                        end else begin
                            r_fmh <= r_fmh + 1'b1;
                        end
                    end
                end else begin
                    r_fcol <= r_fcol + 1'b1;
                    if (mw_last) begin
                        r_fmw <= '0; r_fwc <= r_fwc + 1'b1;
                    end else begin
                        r_fmw <= r_fmw + 1'b1;
                    end
                end
            end
            if (i_cmd.bwd_step) begin
                if ({1'b0, r_bmw} == i_ww - 1'b1) begin
                    r_bmw <= '0;
                    r_bmh <= r_bmh + 1'b1;
                end else begin
                    r_bmw <= r_bmw + 1'b1;
                end
            end
            if (i_cmd.bwd_done) begin
                r_bmh <= '0;
                r_bmw <= '0;
                if ({1'b0, r_bwc} == ow - 1'b1) begin
                    r_bwc <= '0; r_bc0 <= '0;
                    if ({1'b0, r_bhh} == oh - 1'b1) begin
                        r_bhh <= '0; r_br0 <= '0;
                        r_bc <= ({1'b0, r_bc} == i_nc - 1'b1) ? '0 : r_bc + 1'b1;
                    end else begin
                        r_bhh <= r_bhh + 1'b1;
                        r_br0 <= r_br0 + PB'(i_wh);
                    end
                end else begin
                    r_bwc <= r_bwc + 1'b1;
                    r_bc0 <= r_bc0 + PB'(i_ww);
                end
            end
        end
    end
endmodule
